// ----- design/s2dec_pkg.sv -----
// ----------------------------------------------------------------------------
// s2dec_pkg
// shared constants and controller/datapath types for the signed integer to
// decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package s2dec_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned NUM_DIGITS  = 10;
    localparam int unsigned IDX_W       = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic quot_zero;
        logic sign_pending;
        logic last_digit;
    } t_status;

endpackage

`default_nettype wire

// ----- design/s2dec_in_if.sv -----
// ----------------------------------------------------------------------------
// s2dec_in_if
// request channel carrying one signed 32-bit value
// ----------------------------------------------------------------------------
`default_nettype none

interface s2dec_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- design/s2dec_out_if.sv -----
// ----------------------------------------------------------------------------
// s2dec_out_if
// result channel carrying one ascii character and a last flag
// ----------------------------------------------------------------------------
`default_nettype none

interface s2dec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- design/s2dec_dp.sv -----
// ----------------------------------------------------------------------------
// s2dec_dp
// datapath: magnitude register, reciprocal divide-by-ten step, digit store
// and output character register
// ----------------------------------------------------------------------------
`default_nettype none

module s2dec_dp (
    input  wire logic                            i_clk,
    input  wire logic [s2dec_pkg::VALUE_W-1:0]   i_value,
    input  wire s2dec_pkg::t_cmd                 i_cmd,
    output s2dec_pkg::t_status                   o_status,
    output logic [s2dec_pkg::CHAR_W-1:0]         o_character,
    output logic                                 o_last
);

    logic [s2dec_pkg::VALUE_W-1:0]   r_mag,  n_mag;
    logic                            r_neg,  n_neg;
    logic [s2dec_pkg::IDX_W-1:0]     r_cnt,  n_cnt;
    logic [s2dec_pkg::DIGIT_W-1:0]   r_digits [s2dec_pkg::NUM_DIGITS];
    logic [s2dec_pkg::CHAR_W-1:0]    r_char, n_char;
    logic                            r_last, n_last;

    logic [2*s2dec_pkg::VALUE_W-1:0] w_prod;
    logic [s2dec_pkg::VALUE_W-1:0]   w_quot;
    logic [s2dec_pkg::VALUE_W-1:0]   w_quot10;
    logic [s2dec_pkg::VALUE_W-1:0]   w_rem;
    logic [s2dec_pkg::IDX_W-1:0]     w_rd_idx;

    assign w_prod   = {{s2dec_pkg::VALUE_W{1'b0}}, r_mag}
                    * {{s2dec_pkg::VALUE_W{1'b0}}, s2dec_pkg::RECIP_TEN};
    assign w_quot   = s2dec_pkg::VALUE_W'(w_prod >> s2dec_pkg::RECIP_SHIFT);
    assign w_quot10 = (w_quot << 3) + (w_quot << 1);
    assign w_rem    = r_mag - w_quot10;
    assign w_rd_idx = r_cnt - s2dec_pkg::IDX_W'(1);

    always_comb begin
        n_mag  = r_mag;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_char = r_char;
        n_last = r_last;
        if (i_cmd.load) begin
            n_neg = i_value[s2dec_pkg::VALUE_W-1];
            n_mag = i_value[s2dec_pkg::VALUE_W-1] ? (s2dec_pkg::VALUE_W'(0) - i_value)
                                                  : i_value;
            n_cnt = '0;
        end else if (i_cmd.div_step) begin
            n_mag = w_quot;
            n_cnt = r_cnt + s2dec_pkg::IDX_W'(1);
        end else if (i_cmd.emit_sign) begin
            n_neg  = 1'b0;
            n_char = s2dec_pkg::CH_MINUS;
            n_last = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_cnt  = w_rd_idx;
            n_last = (r_cnt == s2dec_pkg::IDX_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        if (i_cmd.emit_digit) begin
            r_char <= s2dec_pkg::CH_ZERO + s2dec_pkg::CHAR_W'(r_digits[w_rd_idx]);
        end else begin
            r_char <= n_char;
        end
        if (i_cmd.div_step) begin
            r_digits[r_cnt] <= w_rem[s2dec_pkg::DIGIT_W-1:0];
        end
    end

    assign o_status.quot_zero    = (w_quot == '0);
    assign o_status.sign_pending = r_neg;
    assign o_status.last_digit   = (r_cnt == s2dec_pkg::IDX_W'(1));
    assign o_character           = r_char;
    assign o_last                = r_last;

endmodule

`default_nettype wire

// ----- design/s2dec_ctrl.sv -----
// ----------------------------------------------------------------------------
// s2dec_ctrl
// controller: sequences load, divide steps and character emission, and
// owns the input ready and output valid handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module s2dec_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output s2dec_pkg::t_cmd          o_cmd,
    input  wire s2dec_pkg::t_status  i_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.quot_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (i_status.sign_pending) begin
                        o_cmd.emit_sign = 1'b1;
                    end else begin
                        o_cmd.emit_digit = 1'b1;
                        if (i_status.last_digit) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/signed_int_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text
// ----------------------------------------------------------------------------
// Each request on the input channel yields its decimal text on the output
// channel, one character per transfer, most significant digit first, with a
// leading '-' for negative values and last set on the final digit; zero gives
// a single '0' and the most negative value converts correctly. A request is
// loaded, then the divide-by-ten loop (a 32x32 reciprocal multiply) yields
// one digit per step, 1 to 10 digits in all, and the characters then leave
// through the output register, one character per cycle while the output is
// not backpressured. The next request is taken while the final character
// still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    s2dec_in_if.sink     i_in,
    s2dec_out_if.source  o_out
);

    s2dec_pkg::t_cmd    w_cmd;
    s2dec_pkg::t_status w_status;

    s2dec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    s2dec_dp u_dp (
        .i_clk       (i_clk),
        .i_value     (i_in.value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_character (o_out.character),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire
